// File: sv/pocket_dictionary_engine_macros.svh
// Assertion helpers for the pocket dictionary engine.
`ifndef POCKET_DICTIONARY_ENGINE_MACROS_SVH
`define POCKET_DICTIONARY_ENGINE_MACROS_SVH
`define PDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/pde_pkg.sv
package pde_pkg;
    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_REMOVE_IF = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_FIND = 2'd1,
        ST_APPLY = 2'd2,
        ST_OUT = 2'd3
    } t_state;

    // Broadcast from the controller to every body cell.
    typedef struct packed {
        logic       cmp;
        logic       ins;
        logic       rem;
        logic [5:0] cnt;
    } t_cell_ctl;
endpackage

// File: sv/pocket_dictionary_engine.sv
// Pocket dictionary engine: a quotient/remainder filter over a row of cells,
// each holding one element as a bucket number and a fingerprint, kept sorted
// by bucket and then by fingerprint, which is the order that a unary header
// and a bucket-ordered body describe. A request is accepted in the idle
// state; in the next cycle every cell compares itself with the request, in
// the cycle after that the row shifts by one place at the insert or remove
// point, and the result beat is then offered from the output state.
// One request is in flight at a time and the next is taken in the cycle after
// the result beat leaves, and a stall on the result holds the beat in the
// output state.
module pocket_dictionary_engine #(
    parameter int CAPACITY = 32,
    parameter int FP_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [4:0] i_quotient,
    input  logic [7:0] i_remainder,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_found,
    output logic       o_rejected,
    output logic [5:0] o_count,
    output logic       o_full_res
);
    localparam int KW = (FP_BITS < 8) ? FP_BITS : 8;

    pde_pkg::t_state r_st, n_st;
    pde_pkg::t_func  r_fn;
    logic [4:0]        r_q;
    logic [KW-1:0]     r_key;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_found, r_rej;
    logic              n_found, n_rej;
    logic              q_ok, hit;
    pde_pkg::t_cell_ctl ctl;

    logic [KW-1:0]       vals [CAPACITY];
    logic [4:0]          bkts [CAPACITY];
    logic [CAPACITY-1:0] lts, eqs;

    assign q_ok = ({1'b0, r_q} < 6'(CAPACITY));
    assign hit = q_ok && (|eqs);

    always_comb begin
        ctl.cmp = (r_st == pde_pkg::ST_FIND);
        ctl.ins = 1'b0;
        ctl.rem = 1'b0;
        ctl.cnt = r_cnt;
        n_cnt = r_cnt; n_found = 1'b0; n_rej = 1'b0;
        if (r_st == pde_pkg::ST_APPLY) begin
            case (r_fn)
                pde_pkg::FN_INSERT: begin
                    if (!q_ok || r_cnt >= 6'(CAPACITY)) n_rej = 1'b1;
                    else begin
                        ctl.ins = 1'b1;
                        n_cnt = r_cnt + 6'd1;
                    end
                end
                pde_pkg::FN_LOOKUP: n_found = hit;
                default: begin
                    if (hit) begin
                        ctl.rem = 1'b1; n_found = 1'b1;
                        n_cnt = r_cnt - 6'd1;
                    end else if (r_fn == pde_pkg::FN_REMOVE) n_rej = 1'b1;
                end
            endcase
        end
    end

    // The first cell sees a "left less" of one, so an insert below every
    // element lands in slot zero.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pde_cell #(.FP_W(KW), .IDX(g)) u_cell (
            .i_clk(i_clk),
            .i_ctl(ctl),
            .i_key_bkt(r_q),
            .i_key(r_key),
            .i_left_bkt((g == 0) ? r_q : bkts[(g + CAPACITY - 1) % CAPACITY]),
            .i_left_val((g == 0) ? r_key : vals[(g + CAPACITY - 1) % CAPACITY]),
            .i_left_lt((g == 0) ? 1'b1 : lts[(g + CAPACITY - 1) % CAPACITY]),
            .i_right_bkt((g == CAPACITY - 1) ? bkts[g] : bkts[(g + 1) % CAPACITY]),
            .i_right_val((g == CAPACITY - 1) ? vals[g] : vals[(g + 1) % CAPACITY]),
            .o_bkt(bkts[g]),
            .o_val(vals[g]),
            .o_lt(lts[g]),
            .o_eq(eqs[g])
        );
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            pde_pkg::ST_IDLE:  if (i_valid) n_st = pde_pkg::ST_FIND;
            pde_pkg::ST_FIND:  n_st = pde_pkg::ST_APPLY;
            pde_pkg::ST_APPLY: n_st = pde_pkg::ST_OUT;
            pde_pkg::ST_OUT:   if (!i_stall) n_st = pde_pkg::ST_IDLE;
            default:           n_st = pde_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_st != pde_pkg::ST_IDLE);
        o_valid = (r_st == pde_pkg::ST_OUT);
        o_found = r_found;
        o_rejected = r_rej;
        o_count = r_cnt;
        o_full_res = (r_cnt == 6'(CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pde_pkg::ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == pde_pkg::ST_APPLY) r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == pde_pkg::ST_IDLE && i_valid) begin
            r_fn <= pde_pkg::t_func'(i_func);
            r_q <= i_quotient;
            r_key <= i_remainder[KW-1:0];
        end
        if (r_st == pde_pkg::ST_APPLY) begin
            r_found <= n_found;
            r_rej <= n_rej;
        end
    end
endmodule

// File: sv/pde_cell.sv
// One body slot holding a bucket number and a fingerprint. The row is kept
// sorted by bucket and then by fingerprint, so the slots that sort below the
// request form a prefix of the row. On an update a slot keeps its value, takes
// the request or takes the value of its left or right neighbour.
module pde_cell #(
    parameter int FP_W = 8,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  pde_pkg::t_cell_ctl   i_ctl,
    input  logic [4:0]           i_key_bkt,
    input  logic [FP_W-1:0]      i_key,
    input  logic [4:0]           i_left_bkt,
    input  logic [FP_W-1:0]      i_left_val,
    input  logic                 i_left_lt,
    input  logic [4:0]           i_right_bkt,
    input  logic [FP_W-1:0]      i_right_val,
    output logic [4:0]           o_bkt,
    output logic [FP_W-1:0]      o_val,
    output logic                 o_lt,
    output logic                 o_eq
);
    logic [FP_W-1:0] r_val;
    logic [FP_W-1:0] n_val;
    logic [4:0]      r_bkt;
    logic [4:0]      n_bkt;
    logic            r_lt, r_eq;
    logic            n_lt, n_eq;
    logic            live;

    // Slots at or above the element count hold nothing and never match.
    assign live = (6'(IDX) < i_ctl.cnt);
    assign n_lt = live && ({r_bkt, r_val} < {i_key_bkt, i_key});
    assign n_eq = live && ({r_bkt, r_val} == {i_key_bkt, i_key});
    assign o_lt = r_lt;
    assign o_eq = r_eq;
    assign o_val = r_val;
    assign o_bkt = r_bkt;

    always_comb begin
        n_val = r_val;
        n_bkt = r_bkt;
        if (i_ctl.ins && !r_lt) begin
            // The first slot not below the request takes it; later ones shift up.
            if (i_left_lt) begin
                n_val = i_key;
                n_bkt = i_key_bkt;
            end else begin
                n_val = i_left_val;
                n_bkt = i_left_bkt;
            end
        end else if (i_ctl.rem && !r_lt) begin
            n_val = i_right_val;
            n_bkt = i_right_bkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
        if (i_ctl.ins || i_ctl.rem) begin
            r_val <= n_val;
            r_bkt <= n_bkt;
        end
    end
endmodule

// File: sv/pde_checker.sv
`include "pocket_dictionary_engine_macros.svh"
module pde_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_found,
    input logic       o_rejected,
    input logic [5:0] o_count,
    input logic       o_full_res
);
    `PDE_ASSERT_IMP(a_full, i_clk, i_rst_n, o_valid, o_full_res == (o_count == 6'd32))
    `PDE_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !(o_found && o_rejected))
    `PDE_ASSERT_IMP(a_bound, i_clk, i_rst_n, o_valid, o_count <= 6'd32)
    `PDE_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_count))
    `PDE_ASSERT_NXT(a_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind pocket_dictionary_engine pde_checker u_chk (.*);

// File: sim/pocket_dictionary_engine_tb.sv
module pocket_dictionary_engine_tb;
    localparam int NSLOT = 32;
    localparam int RANDOM_BEATS = 1500;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_func;
    logic [4:0] i_quotient;
    logic [7:0] i_remainder;
    logic       o_valid;
    logic       i_stall;
    logic       o_found;
    logic       o_rejected;
    logic [5:0] o_count;
    logic       o_full_res;

    typedef struct packed {
        logic       found;
        logic       rejected;
        logic [5:0] count;
        logic       full;
    } t_answer;

    typedef struct {
        pde_pkg::t_func fn;
        logic [4:0]     q;
        logic [7:0]     r;
        logic           fixed;
        t_answer        ans;
    } t_row;

    pocket_dictionary_engine dut (.*);

    // Shadow filter: one bucket number per element, kept as a list ordered like the body.
    logic [4:0] shadow_q[$];
    logic [7:0] shadow_r[$];
    t_answer    pending[$];
    int         errors = 0;
    int         send_idle = 26;
    int         recv_idle = 52;

    function automatic t_answer filter_step(pde_pkg::t_func fn, logic [4:0] q, logic [7:0] r);
        t_answer a;
        int pos;
        logic hit;
        a = '0;
        // Sorted slot: past smaller buckets and smaller fingerprints in this bucket.
        pos = 0;
        while (pos < shadow_q.size() && (shadow_q[pos] < q ||
               (shadow_q[pos] == q && shadow_r[pos] < r)))
            pos++;
        hit = pos < shadow_q.size() && shadow_q[pos] == q && shadow_r[pos] == r;
        case (fn)
            pde_pkg::FN_LOOKUP: a.found = hit;
            pde_pkg::FN_INSERT: begin
                if (shadow_q.size() >= NSLOT) begin
                    a.rejected = 1'b1;
                end else begin
                    shadow_q.insert(pos, q);
                    shadow_r.insert(pos, r);
                end
            end
            default: begin
                if (hit) begin
                    shadow_q.delete(pos);
                    shadow_r.delete(pos);
                    a.found = 1'b1;
                end else if (fn == pde_pkg::FN_REMOVE) begin
                    a.rejected = 1'b1;
                end
            end
        endcase
        a.count = 6'(shadow_q.size());
        a.full = shadow_q.size() == NSLOT;
        return a;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_beat(pde_pkg::t_func fn, logic [4:0] q, logic [7:0] r,
                             logic fixed, t_answer ans);
        t_answer exp_ans;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_quotient  <= q;
        i_remainder <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_ans = filter_step(fn, q, r);
        if (fixed && exp_ans != ans) begin
            $display("%0t table row disagrees: table %h, predicted %h", $time, ans, exp_ans);
            errors++;
        end
        pending.push_back(exp_ans);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending.size() == 0) begin
                    $display("%0t unexpected beat: found %b rej %b count %0d full %b",
                             $time, o_found, o_rejected, o_count, o_full_res);
                    errors++;
                end else begin
                    t_answer e;
                    e = pending.pop_front();
                    if (o_found !== e.found) begin
                        $display("%0t found: expected %b actual %b", $time, e.found, o_found);
                        errors++;
                    end
                    if (o_rejected !== e.rejected) begin
                        $display("%0t rejected: expected %b actual %b",
                                 $time, e.rejected, o_rejected);
                        errors++;
                    end
                    if (o_count !== e.count) begin
                        $display("%0t count: expected %0d actual %0d", $time, e.count, o_count);
                        errors++;
                    end
                    if (o_full_res !== e.full) begin
                        $display("%0t full_res: expected %b actual %b",
                                 $time, e.full, o_full_res);
                        errors++;
                    end
                end
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < recv_idle);
    end

    initial begin
        t_row rows[$];
        t_row row;
        int k;
        int hot_q;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = pde_pkg::FN_LOOKUP;
        i_quotient = '0;
        i_remainder = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty store, extremes, duplicates, both removes of absent pairs.
        rows = '{
            '{pde_pkg::FN_LOOKUP,    5'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0, 1'b0}},
            '{pde_pkg::FN_REMOVE,    5'd31, 8'd255, 1'b1, '{1'b0, 1'b1, 6'd0, 1'b0}},
            '{pde_pkg::FN_REMOVE_IF, 5'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0, 1'b0}},
            '{pde_pkg::FN_INSERT,    5'd31, 8'd255, 1'b1, '{1'b0, 1'b0, 6'd1, 1'b0}},
            '{pde_pkg::FN_INSERT,    5'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd2, 1'b0}},
            '{pde_pkg::FN_INSERT,    5'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd3, 1'b0}},
            '{pde_pkg::FN_INSERT,    5'd0,  8'h55,  1'b0, '0},
            '{pde_pkg::FN_INSERT,    5'd0,  8'haa,  1'b0, '0},
            '{pde_pkg::FN_LOOKUP,    5'd31, 8'd255, 1'b1, '{1'b1, 1'b0, 6'd5, 1'b0}},
            '{pde_pkg::FN_LOOKUP,    5'd30, 8'd255, 1'b1, '{1'b0, 1'b0, 6'd5, 1'b0}},
            '{pde_pkg::FN_REMOVE,    5'd0,  8'd0,   1'b1, '{1'b1, 1'b0, 6'd4, 1'b0}},
            '{pde_pkg::FN_LOOKUP,    5'd0,  8'd0,   1'b0, '0},
            '{pde_pkg::FN_REMOVE_IF, 5'd0,  8'd0,   1'b0, '0},
            '{pde_pkg::FN_REMOVE_IF, 5'd0,  8'd0,   1'b0, '0},
            '{pde_pkg::FN_REMOVE,    5'd0,  8'h55,  1'b0, '0},
            '{pde_pkg::FN_REMOVE_IF, 5'd31, 8'd255, 1'b0, '0},
            '{pde_pkg::FN_REMOVE,    5'd0,  8'haa,  1'b1, '{1'b1, 1'b0, 6'd0, 1'b0}}
        };
        foreach (rows[i]) send_beat(rows[i].fn, rows[i].q, rows[i].r,
                                    rows[i].fixed, rows[i].ans);
        // Fill to capacity, then an insert that must be refused.
        for (k = 0; k < NSLOT; k++)
            send_beat(pde_pkg::FN_INSERT, 5'(k), 8'(k * 7), 1'b0, '0);
        send_beat(pde_pkg::FN_INSERT, 5'd9, 8'd9, 1'b1, '{1'b0, 1'b1, 6'd32, 1'b1});
        for (k = 0; k < NSLOT; k++)
            send_beat(pde_pkg::FN_REMOVE, 5'(k), 8'(k * 7), 1'b0, '0);

        // Random part: few buckets and fingerprints so hits and fills are common.
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS / 3) begin
                send_idle = 52;
                recv_idle = 26;
            end else if (k == 2 * RANDOM_BEATS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            hot_q = $urandom_range(3);
            row.fn = pde_pkg::t_func'($urandom_range(9) < 4 ? pde_pkg::FN_INSERT
                                                            : $urandom_range(3));
            row.q = ($urandom_range(3) == 0) ? 5'($urandom) : 5'(hot_q * 9);
            row.r = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3) * 85);
            send_beat(row.fn, row.q, row.r, 1'b0, '0);
        end
        i_valid <= 1'b0;
        recv_idle = 0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
